@@ sv/lsft_pkg.sv @@
// Shared constants and types of the learning switch forwarding table.
`timescale 1ns / 1ps

package lsft_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int MAX_PORTS       = 16;
  localparam int ADDR_W          = 16;
  localparam int PORT_W          = 5;
  localparam int MASK_W          = 16;
  localparam int PORT_COUNT_RST  = 16;

  // Ports in use saturate at the smaller of the port limit and the mask width.
  localparam int PORT_SAT = (MAX_PORTS < MASK_W) ? MAX_PORTS : MASK_W;

  // Table entries held by one cell of the chain.
  localparam int CELL_ENTRIES = 32;
  localparam int SLOT_W       = $clog2(CELL_ENTRIES);

  // Lookup transaction as it walks the chain of cells.
  typedef struct packed {
    logic              live;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [PORT_W-1:0] ingress;
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
    logic              src_hit;
  } query_t;

  // Learn write, broadcast to every cell; the cell owning the slot takes it.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } wr_t;

endpackage

@@ sv/lsft_cell.sv @@
// One cell of the address table chain: a slice of entries and a lookup stage.
`timescale 1ns / 1ps

module lsft_cell #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IDX_W-1:0]    fill_count,
  input  lsft_pkg::wr_t       wr,
  input  lsft_pkg::query_t    q_in,
  output lsft_pkg::query_t    q_out
);

  localparam int CE     = lsft_pkg::CELL_ENTRIES;
  localparam int SW     = lsft_pkg::SLOT_W;
  localparam int BASE   = CELL_IDX * CE;
  localparam int CSEL_W = IDX_W - SW;

  logic [lsft_pkg::ADDR_W-1:0] addr_r [CE];
  logic [lsft_pkg::PORT_W-1:0] port_r [CE];

  logic [CE-1:0]               ent_valid;
  logic [CE-1:0]               dst_match;
  logic [CE-1:0]               dst_first;
  logic [CE-1:0]               src_match;
  logic [lsft_pkg::PORT_W-1:0] sel_port;
  logic                        wr_here;
  logic [SW-1:0]               wr_slot;
  lsft_pkg::query_t            q_nxt;
  lsft_pkg::query_t            q_out_r;

  assign wr_here = wr.en && (fill_count[IDX_W-1:SW] == CSEL_W'(CELL_IDX));
  assign wr_slot = fill_count[SW-1:0];

  always_ff @(posedge clk) begin
    if (wr_here) begin
      addr_r[wr_slot] <= wr.addr;
      port_r[wr_slot] <= wr.port;
    end
  end

  // Entries below the fill count are live; everything else is never matched.
  always_comb begin
    for (int j = 0; j < CE; j++) begin
      ent_valid[j] = IDX_W'(BASE + j) < fill_count;
      dst_match[j] = ent_valid[j] && (addr_r[j] == q_in.dst);
      src_match[j] = ent_valid[j] && (addr_r[j] == q_in.src);
    end
  end

  // Isolate the lowest matching slot: oldest insertion wins.
  assign dst_first = dst_match & (~dst_match + CE'(1));

  always_comb begin
    sel_port = '0;
    for (int j = 0; j < CE; j++) begin
      sel_port = sel_port | ({lsft_pkg::PORT_W{dst_first[j]}} & port_r[j]);
    end
  end

  always_comb begin
    q_nxt         = q_in;
    q_nxt.src_hit = q_in.src_hit | (|src_match);
    if (!q_in.dst_hit && (|dst_match)) begin
      q_nxt.dst_hit  = 1'b1;
      q_nxt.dst_port = sel_port;
    end
  end

  // Advance the transaction one cell per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_out_r.live <= 1'b0;
    end else begin
      q_out_r <= q_nxt;
    end
  end

  assign q_out = q_out_r;

endmodule

@@ sv/learning_switch_forward_table_unit.sv @@
// Top level of the learning switch forwarding table.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------------
//   in       | in_valid / in_stall | in_source_addr, in_dest_addr, in_ingress_port
//   out      | out_valid/out_stall | out_port_mask, out_dest_port, out_flooded,
//            |                     | out_learned, out_table_full
//   cfg      | cfg_wr_en           | cfg_wr_data (port_count)
//
// The lookup walks the chain of cells at one cell of 32 entries per cycle; the
// end of the chain is captured into the hold register, and once the output is free
// the source is learned and the output register is loaded.
// One frame is in flight at a time; in_stall is high from accept to commit.
// Reset empties the table through the fill count alone; there is no clearing pass.
// A stalled output holds the finished frame and keeps in_stall high.
`timescale 1ns / 1ps

module learning_switch_forward_table_unit #(
  parameter int TABLE_DEPTH = lsft_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [4:0]                  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lsft_pkg::ADDR_W-1:0] in_source_addr,
  input  logic [lsft_pkg::ADDR_W-1:0] in_dest_addr,
  input  logic [lsft_pkg::PORT_W-1:0] in_ingress_port,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lsft_pkg::MASK_W-1:0] out_port_mask,
  output logic [lsft_pkg::PORT_W-1:0] out_dest_port,
  output logic                        out_flooded,
  output logic                        out_learned,
  output logic                        out_table_full
);

  localparam int CE        = lsft_pkg::CELL_ENTRIES;
  localparam int PW        = lsft_pkg::PORT_W;
  localparam int MW        = lsft_pkg::MASK_W;
  localparam int NUM_CELLS = (TABLE_DEPTH + CE - 1) / CE;
  localparam int IDX_W     = $clog2(NUM_CELLS * CE + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      fill_count_r, fill_count_nxt;
  logic [4:0]            port_count_r, port_count_nxt;
  lsft_pkg::query_t      hold_r, hold_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [MW-1:0]         out_mask_r, out_mask_nxt;
  logic [PW-1:0]         out_dport_r, out_dport_nxt;
  logic                  out_flooded_r, out_flooded_nxt;
  logic                  out_learned_r, out_learned_nxt;
  logic                  out_full_r, out_full_nxt;

  lsft_pkg::query_t      head_q;
  lsft_pkg::query_t      chain [NUM_CELLS+1];
  lsft_pkg::wr_t         wr;
  logic                  out_free;
  logic                  commit;
  logic                  can_learn;
  logic [PW-1:0]         ports_used;
  logic [MW:0]           flood_ext;
  logic [MW-1:0]         flood_mask;
  logic [MW-1:0]         known_mask;

  // Feed the head of the chain on the accept cycle.
  always_comb begin
    head_q          = '0;
    head_q.live     = (state_r == ST_IDLE) && in_valid;
    head_q.src      = in_source_addr;
    head_q.dst      = in_dest_addr;
    head_q.ingress  = in_ingress_port;
  end

  assign chain[0] = head_q;

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    lsft_cell #(
      .CELL_IDX (c),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .fill_count (fill_count_r),
      .wr         (wr),
      .q_in       (chain[c]),
      .q_out      (chain[c+1])
    );
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == ST_DONE) && out_free;
  assign can_learn = !hold_r.src_hit && (fill_count_r < IDX_W'(TABLE_DEPTH));

  assign wr.en   = commit && can_learn;
  assign wr.addr = hold_r.src;
  assign wr.port = hold_r.ingress;

  // Flood mask: every port in use except the ingress port.
  assign ports_used = (port_count_r > PW'(lsft_pkg::PORT_SAT)) ? PW'(lsft_pkg::PORT_SAT)
                                                               : port_count_r;
  assign flood_ext  = ((MW+1)'(1) << ports_used) - (MW+1)'(1);

  always_comb begin
    flood_mask = flood_ext[MW-1:0];
    if ((hold_r.ingress >= PW'(1)) && (hold_r.ingress <= ports_used)) begin
      flood_mask = flood_mask & ~(MW'(1) << (hold_r.ingress - PW'(1)));
    end
    known_mask = '0;
    if ((hold_r.dst_port >= PW'(1)) && (hold_r.dst_port <= PW'(MW))) begin
      known_mask = MW'(1) << (hold_r.dst_port - PW'(1));
    end
  end

  always_comb begin
    state_nxt       = state_r;
    fill_count_nxt  = fill_count_r;
    port_count_nxt  = port_count_r;
    hold_nxt        = hold_r;
    out_valid_nxt   = out_valid_r;
    out_mask_nxt    = out_mask_r;
    out_dport_nxt   = out_dport_r;
    out_flooded_nxt = out_flooded_r;
    out_learned_nxt = out_learned_r;
    out_full_nxt    = out_full_r;

    if (cfg_wr_en) begin
      port_count_nxt = cfg_wr_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (chain[NUM_CELLS].live) begin
          hold_nxt  = chain[NUM_CELLS];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_mask_nxt    = hold_r.dst_hit ? known_mask : flood_mask;
          out_dport_nxt   = hold_r.dst_hit ? hold_r.dst_port : '0;
          out_flooded_nxt = !hold_r.dst_hit;
          out_learned_nxt = can_learn;
          out_full_nxt    = !hold_r.src_hit && !can_learn;
          if (can_learn) begin
            fill_count_nxt = fill_count_r + IDX_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    hold_r        <= hold_nxt;
    out_mask_r    <= out_mask_nxt;
    out_dport_r   <= out_dport_nxt;
    out_flooded_r <= out_flooded_nxt;
    out_learned_r <= out_learned_nxt;
    out_full_r    <= out_full_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_count_r <= '0;
      port_count_r <= 5'(lsft_pkg::PORT_COUNT_RST);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      port_count_r <= port_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_port_mask  = out_mask_r;
  assign out_dest_port  = out_dport_r;
  assign out_flooded    = out_flooded_r;
  assign out_learned    = out_learned_r;
  assign out_table_full = out_full_r;

endmodule

@@ sv/lsft_checker.sv @@
// Port-level checks of the forwarding table and their binding to the top level.
`timescale 1ns / 1ps

module lsft_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lsft_pkg::MASK_W-1:0] out_port_mask,
  input logic [lsft_pkg::PORT_W-1:0] out_dest_port,
  input logic                        out_flooded,
  input logic                        out_learned,
  input logic                        out_table_full
);

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_port_mask)
                                  && $stable(out_dest_port) && $stable(out_flooded)))
    else $error("stalled result changed");

  // One frame in flight: an accepted transaction blocks the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after accept");

  // A flooded frame has no learned destination port.
  a_flood_no_port: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flooded) |-> (out_dest_port == '0))
    else $error("flooded frame reports a destination port");

  // A known destination goes to at most one port.
  a_known_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_flooded) |-> $onehot0(out_port_mask))
    else $error("known destination sent to several ports");

  a_learn_or_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_learned && out_table_full))
    else $error("learned and table full at once");

endmodule

bind learning_switch_forward_table_unit lsft_checker u_lsft_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_port_mask  (out_port_mask),
  .out_dest_port  (out_dest_port),
  .out_flooded    (out_flooded),
  .out_learned    (out_learned),
  .out_table_full (out_table_full)
);

@@ tb/tb_learning_switch_forward_table_unit.sv @@
// Self-checking testbench for the learning switch forwarding table unit.
`timescale 1ns / 1ps

module tb_learning_switch_forward_table_unit;

  localparam int          AW             = lsft_pkg::ADDR_W;
  localparam int          PW             = lsft_pkg::PORT_W;
  localparam int          MW             = lsft_pkg::MASK_W;
  localparam int          DEPTH          = lsft_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_AT        = 200;
  localparam int unsigned HOLD_LEN       = 300;
  localparam int unsigned PHASE_FRAMES   = 122;

  typedef struct packed {
    logic [AW-1:0] src;
    logic [AW-1:0] dst;
    logic [PW-1:0] ingress;
  } frame_t;

  typedef struct packed {
    logic [MW-1:0] port_mask;
    logic [PW-1:0] dest_port;
    logic          flooded;
    logic          learned;
    logic          table_full;
  } fwd_result_t;

  logic          clk             = 1'b0;
  logic          rst_n           = 1'b0;
  logic          cfg_wr_en       = 1'b0;
  logic [4:0]    cfg_wr_data     = '0;
  logic          in_valid        = 1'b0;
  logic          in_stall;
  logic [AW-1:0] in_source_addr  = '0;
  logic [AW-1:0] in_dest_addr    = '0;
  logic [PW-1:0] in_ingress_port = '0;
  logic          out_valid;
  logic          out_stall       = 1'b0;
  logic [MW-1:0] out_port_mask;
  logic [PW-1:0] out_dest_port;
  logic          out_flooded;
  logic          out_learned;
  logic          out_table_full;

  // Predictor state: learned entries in insertion order and the port count.
  logic [AW-1:0] learned_addr [DEPTH];
  logic [PW-1:0] learned_port [DEPTH];
  int unsigned   learned_count = 0;
  logic [4:0]    ports_cfg     = 5'(lsft_pkg::PORT_COUNT_RST);

  frame_t        frame_q[$];
  fwd_result_t   decision_q[$];
  logic [AW-1:0] sources_sent[$];

  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned src_gap      = 0;
  int unsigned sink_gap     = 0;
  int unsigned hold_left    = 0;
  int unsigned idle_cycles  = 0;
  logic        src_idle_en  = 1'b1;
  logic        sink_idle_en = 1'b1;
  logic        src_take;
  logic        stall_next;
  fwd_result_t want, got, pred;

  learning_switch_forward_table_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_source_addr (in_source_addr),
    .in_dest_addr   (in_dest_addr),
    .in_ingress_port(in_ingress_port),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_port_mask  (out_port_mask),
    .out_dest_port  (out_dest_port),
    .out_flooded    (out_flooded),
    .out_learned    (out_learned),
    .out_table_full (out_table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Forwarding decision for one frame; learns the source as a side effect.
  function automatic fwd_result_t forward_decision(frame_t f);
    fwd_result_t   r;
    logic          dst_hit;
    logic          src_hit;
    logic [PW-1:0] dst_port;
    logic [31:0]   flood;
    int unsigned   n;
    r        = '0;
    dst_hit  = 1'b0;
    src_hit  = 1'b0;
    dst_port = '0;
    // Look up the destination against the table as it stood before learning.
    for (int unsigned i = 0; i < learned_count; i++) begin
      if (!dst_hit && learned_addr[i] == f.dst) begin
        dst_hit  = 1'b1;
        dst_port = learned_port[i];
      end
      if (learned_addr[i] == f.src) src_hit = 1'b1;
    end
    if (!src_hit) begin
      if (learned_count < DEPTH) begin
        learned_addr[learned_count] = f.src;
        learned_port[learned_count] = f.ingress;
        learned_count++;
        r.learned = 1'b1;
      end else begin
        r.table_full = 1'b1;
      end
    end
    if (dst_hit) begin
      r.dest_port = dst_port;
      if (dst_port >= 1 && dst_port <= MW) r.port_mask = MW'(1) << (dst_port - 5'd1);
    end else begin
      n     = (ports_cfg > lsft_pkg::PORT_SAT) ? lsft_pkg::PORT_SAT : ports_cfg;
      flood = (32'd1 << n) - 32'd1;
      if (f.ingress >= 1 && f.ingress <= n) flood[f.ingress - 5'd1] = 1'b0;
      r.port_mask = flood[MW-1:0];
      r.flooded   = 1'b1;
    end
    return r;
  endfunction

  // Driver: present the oldest pending frame, hold it while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      src_take = in_valid && !in_stall;
      if (src_take) begin
        pred = forward_decision(frame_q.pop_front());
        decision_q = {decision_q, pred};
        src_gap = src_idle_en ? idle_len() : 0;
      end
      if (!in_valid || src_take) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (frame_q.size() > 0) begin
          in_valid        <= 1'b1;
          in_source_addr  <= frame_q[0].src;
          in_dest_addr    <= frame_q[0].dst;
          in_ingress_port <= frame_q[0].ingress;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction, then pick the next stall value.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_port_mask, out_dest_port, out_flooded, out_learned, out_table_full};
        if (decision_q.size() == 0) begin
          $error("result transaction with no decision pending");
          fail_count++;
        end else begin
          want = decision_q.pop_front();
          if (got.port_mask !== want.port_mask) begin
            $error("out_port_mask: expected %h, actual %h", want.port_mask, got.port_mask);
            fail_count++;
          end
          if (got.dest_port !== want.dest_port) begin
            $error("out_dest_port: expected %0d, actual %0d", want.dest_port, got.dest_port);
            fail_count++;
          end
          if (got.flooded !== want.flooded) begin
            $error("out_flooded: expected %b, actual %b", want.flooded, got.flooded);
            fail_count++;
          end
          if (got.learned !== want.learned) begin
            $error("out_learned: expected %b, actual %b", want.learned, got.learned);
            fail_count++;
          end
          if (got.table_full !== want.table_full) begin
            $error("out_table_full: expected %b, actual %b", want.table_full, got.table_full);
            fail_count++;
          end
        end
        results_seen++;
        // Back up the unit once for a long stretch.
        if (results_seen == HOLD_AT) hold_left = HOLD_LEN;
      end
      stall_next = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (sink_gap == 0 && sink_idle_en && $urandom_range(0, 3) == 0) sink_gap = idle_len();
        if (sink_gap > 0) begin
          sink_gap--;
          stall_next = 1'b1;
        end
      end
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else if (rst_n) idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_frame(input logic [AW-1:0] src, input logic [AW-1:0] dst,
                            input logic [PW-1:0] ingress);
    frame_t f;
    f = '{src, dst, ingress};
    frame_q = {frame_q, f};
    sources_sent = {sources_sent, src};
  endtask

  task automatic push_random_frame();
    logic [AW-1:0] src;
    logic [AW-1:0] dst;
    logic [PW-1:0] ingress;
    int unsigned   r;
    // Mix new sources (fills the table) with ones already sent.
    if ($urandom_range(0, 99) < 45 || sources_sent.size() == 0) src = AW'($urandom());
    else src = sources_sent[$urandom_range(0, sources_sent.size() - 1)];
    r = $urandom_range(0, 99);
    if (r < 60 && sources_sent.size() > 0)
      dst = sources_sent[$urandom_range(0, sources_sent.size() - 1)];
    else if (r < 70) dst = src;
    else dst = AW'($urandom());
    if ($urandom_range(0, 99) < 85) ingress = PW'($urandom_range(1, 16));
    else ingress = PW'($urandom_range(0, 31));
    push_frame(src, dst, ingress);
  endtask

  // Wait until every frame has been answered, then let the unit settle.
  task automatic drain();
    while (frame_q.size() != 0 || decision_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_port_count(input logic [4:0] value);
    drain();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    ports_cfg = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [4:0] phase_ports [6];
    phase_ports = '{5'd16, 5'd7, 5'd31, 5'd10, 5'd1, 5'd0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Port count at its reset value.
    push_frame(16'h0000, 16'h0000, 5'd1);   // unknown source equal to destination floods
    push_frame(16'hFFFF, 16'h0000, 5'd16);
    push_frame(16'hFFFF, 16'hFFFF, 5'd16);  // known source, known destination
    push_frame(16'hFFFF, 16'h1234, 5'd3);   // known source still excluded by ingress
    push_frame(16'hA5A5, 16'h5A5A, 5'd0);   // ingress port zero
    push_frame(16'h5A5A, 16'hA5A5, 5'd31);  // destination learned on port zero
    push_frame(16'h0001, 16'h5A5A, 5'd17);  // destination learned above the mask width
    push_frame(16'h0002, 16'h0001, 5'd2);

    write_port_count(5'd0);                 // no port in use: empty flood
    push_frame(16'hFFFF, 16'h4444, 5'd1);
    push_frame(16'h0000, 16'h0000, 5'd1);
    write_port_count(5'd1);
    push_frame(16'h1111, 16'h4444, 5'd1);
    push_frame(16'h1112, 16'h4444, 5'd2);
    write_port_count(5'd31);                // saturates at the port limit
    push_frame(16'h2222, 16'h4444, 5'd16);
    push_frame(16'h2223, 16'h4444, 5'd20);
    write_port_count(5'd4);                 // learned port above the count is still used
    push_frame(16'h3333, 16'hFFFF, 5'd2);

    foreach (phase_ports[p]) begin
      write_port_count(phase_ports[p]);
      // Run one phase flat out on both sides.
      src_idle_en  = (p != 3);
      sink_idle_en = (p != 3);
      repeat (PHASE_FRAMES) push_random_frame();
    end

    drain();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
